/* rtl/core/vgl_pkg.sv */
// ----------------------------------------------------------------------------
// vgl_pkg: shared types and constants of the velocity governor limiter
// Widths, register indexes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package vgl_pkg;

    localparam int SPEED_WIDTH   = 16;
    localparam int QUALITY_WIDTH = 24;
    localparam int ADDR_WIDTH    = 5;

    localparam logic [16:0] ONE_Q15 = 17'd32768;

    typedef enum logic [2:0] {
        REG_MAX_ROT   = 3'd0,
        REG_MAX_ADV   = 3'd1,
        REG_GAIN      = 3'd2,
        REG_SAFE      = 3'd3,
        REG_DANGER    = 3'd4,
        REG_FLOOR     = 3'd5
    } reg_index_t;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch input beat
        OP_GOV_DIV,   // start quotient (q - safe) << 15 / range
        OP_GOV_END,   // governor from quotient
        OP_EFF,       // scaled limits
        OP_ROT,       // clamp rotation, start fraction divide
        OP_FRAC_END,  // latch fraction quotient
        OP_LIM,       // advance scale factor
        OP_NORM,      // squared norm and advance limit
        OP_SQRT,      // start square root
        OP_DIVX,      // start x rescale divide
        OP_DIVX_END,
        OP_DIVY,
        OP_DIVY_END
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic is_command;
        logic div_busy;
        logic sqrt_busy;
        logic need_rescale;
        logic n_zero;
    } stat_t;

endpackage

/* rtl/core/vgl_div.sv */
// ----------------------------------------------------------------------------
// vgl_div: restoring divider
// One quotient bit per cycle, 40-bit dividend over a 32-bit divisor.
// ----------------------------------------------------------------------------
module vgl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [39:0] quotient
);
    logic [39:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;
    logic [33:0] diff;

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = q_reg;
    assign trial    = {r_reg[31:0], q_reg[39]};
    assign diff     = {1'b0, trial} - {2'b00, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (start) begin
            q_reg   <= dividend;
            r_reg   <= 33'd0;
            d_reg   <= divisor;
            cnt_reg <= 6'd40;
        end else if (busy) begin
            if (!diff[33]) begin
                r_reg <= diff[32:0];
                q_reg <= {q_reg[38:0], 1'b1};
            end else begin
                r_reg <= trial;
                q_reg <= {q_reg[38:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
    end
endmodule

/* rtl/core/vgl_sqrt.sv */
// ----------------------------------------------------------------------------
// vgl_sqrt: integer square root
// One result bit per cycle over a 34-bit radicand.
// ----------------------------------------------------------------------------
module vgl_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] radicand,
    output logic        busy,
    output logic [16:0] root
);
    logic [33:0] n_reg;
    logic [16:0] res_reg;
    logic [18:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic [18:0] cur;
    logic [18:0] trial;

    assign busy  = (cnt_reg != 5'd0);
    assign root  = res_reg;
    assign cur   = {rem_reg[16:0], n_reg[33:32]};
    assign trial = {res_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 5'd0;
        end else if (start) begin
            n_reg   <= radicand;
            res_reg <= 17'd0;
            rem_reg <= 19'd0;
            cnt_reg <= 5'd17;
        end else if (busy) begin
            n_reg <= {n_reg[31:0], 2'b00};
            if (cur >= trial) begin
                rem_reg <= cur - trial;
                res_reg <= {res_reg[15:0], 1'b1};
            end else begin
                rem_reg <= cur;
                res_reg <= {res_reg[15:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 5'd1;
        end
    end
endmodule

/* rtl/core/vgl_datapath.sv */
// ----------------------------------------------------------------------------
// vgl_datapath: arithmetic of the limiter
// Holds the beat, the governor factor and intermediates; steps on command.
// ----------------------------------------------------------------------------
module vgl_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  vgl_pkg::ctrl_t          ctrl,
    output vgl_pkg::stat_t          stat,
    input  logic                    in_command,
    input  logic [23:0]             in_quality,
    input  logic signed [15:0]      in_rot,
    input  logic signed [15:0]      in_x,
    input  logic signed [15:0]      in_y,
    input  logic [14:0]             max_rot,
    input  logic [14:0]             max_adv,
    input  logic [15:0]             gain,
    input  logic [23:0]             safe,
    input  logic [23:0]             danger,
    input  logic [15:0]             floor_q,
    output logic signed [15:0]      rot_res,
    output logic signed [15:0]      x_res,
    output logic signed [15:0]      y_res
);
    logic        cmd_reg;
    logic [23:0] q_reg;
    logic signed [16:0] rot_reg;
    logic [15:0] xm_reg, ym_reg;
    logic        xs_reg, ys_reg;
    logic [16:0] gov_reg;
    logic [15:0] eff_rot_reg, eff_adv_reg;
    logic [16:0] frac_reg;
    logic [16:0] s_reg;
    logic [15:0] lim_reg;
    logic [32:0] n2_reg;
    logic        rescale_reg;
    logic [15:0] xo_reg, yo_reg;

    logic        div_start;
    logic [39:0] div_a;
    logic [31:0] div_b;
    logic        div_busy;
    logic [39:0] div_q;
    logic        sq_start;
    logic        sq_busy;
    logic [16:0] sq_root;

    logic [24:0] range_w;
    logic [24:0] d_w;
    logic [16:0] flo_w;
    logic [16:0] f_w;
    logic [31:0] pm_w;
    logic signed [16:0] eff_rot_s_w;
    logic signed [16:0] rot_clamp_w;
    logic [16:0] mag_rot_w;
    logic [32:0] lim2_w;

    vgl_div u_div (.aclk, .aresetn, .start(div_start), .dividend(div_a),
                   .divisor(div_b), .busy(div_busy), .quotient(div_q));
    vgl_sqrt u_sqrt (.aclk, .aresetn, .start(sq_start), .radicand({1'b0, n2_reg}),
                     .busy(sq_busy), .root(sq_root));

    assign range_w   = {1'b0, danger} - {1'b0, safe};
    assign d_w       = {1'b0, q_reg} - {1'b0, safe};
    assign flo_w     = ({1'b0, floor_q} > vgl_pkg::ONE_Q15) ? vgl_pkg::ONE_Q15
                                                             : {1'b0, floor_q};
    assign eff_rot_s_w = $signed({1'b0, eff_rot_reg});

    // The fraction divide must see the rotation after the clamp.
    always_comb begin
        rot_clamp_w = rot_reg;
        if (rot_reg > eff_rot_s_w)
            rot_clamp_w = eff_rot_s_w;
        else if (rot_reg < -eff_rot_s_w)
            rot_clamp_w = -eff_rot_s_w;
    end

    assign mag_rot_w = rot_clamp_w[16] ? 17'(-rot_clamp_w) : 17'(rot_clamp_w);
    assign pm_w      = 32'({16'd0, gain} * {15'd0, frac_reg});
    assign lim2_w    = 33'({17'd0, lim_reg} * {17'd0, lim_reg});

    always_comb begin
        logic [39:0] t;
        t   = div_q;
        f_w = vgl_pkg::ONE_Q15;
        if (danger > safe && q_reg > safe) begin
            f_w = (t >= 40'd32768) ? 17'd0 : 17'(40'd32768 - t);
        end
        if (f_w < flo_w) f_w = flo_w;
    end

    always_comb begin
        div_start = 1'b0;
        div_a     = 40'd0;
        div_b     = 32'd1;
        sq_start  = 1'b0;
        case (ctrl.op)
            vgl_pkg::OP_GOV_DIV: begin
                div_start = 1'b1;
                div_a     = {d_w[23:0], 15'd0, 1'b0} >> 1;
                div_b     = {8'd0, range_w[23:0]};
            end
            vgl_pkg::OP_ROT: begin
                div_start = 1'b1;
                div_a     = 40'({mag_rot_w, 15'd0});
                div_b     = {16'd0, eff_rot_reg};
            end
            vgl_pkg::OP_SQRT: sq_start = 1'b1;
            vgl_pkg::OP_DIVX: begin
                div_start = 1'b1;
                div_a     = 40'({16'd0, xm_reg} * {16'd0, lim_reg});
                div_b     = {15'd0, sq_root};
            end
            vgl_pkg::OP_DIVY: begin
                div_start = 1'b1;
                div_a     = 40'({16'd0, ym_reg} * {16'd0, lim_reg});
                div_b     = {15'd0, sq_root};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gov_reg <= vgl_pkg::ONE_Q15;
        end else begin
            case (ctrl.op)
                vgl_pkg::OP_LOAD: begin
                    cmd_reg <= in_command;
                    q_reg   <= in_quality;
                    rot_reg <= 17'(in_rot);
                    xs_reg  <= in_x[15];
                    ys_reg  <= in_y[15];
                    xm_reg  <= in_x[15] ? 16'(-in_x) : 16'(in_x);
                    ym_reg  <= in_y[15] ? 16'(-in_y) : 16'(in_y);
                end
                vgl_pkg::OP_GOV_END: gov_reg <= f_w;
                vgl_pkg::OP_EFF: begin
                    eff_rot_reg <= 16'(({17'd0, max_rot} * {15'd0, gov_reg}) >> 15);
                    eff_adv_reg <= 16'(({17'd0, max_adv} * {15'd0, gov_reg}) >> 15);
                end
                vgl_pkg::OP_ROT: rot_reg <= rot_clamp_w;
                vgl_pkg::OP_FRAC_END: begin
                    frac_reg <= (eff_rot_reg == 16'd0) ? 17'd0 : div_q[16:0];
                end
                vgl_pkg::OP_LIM: begin
                    s_reg <= ((pm_w >> 14) >= 32'd32768) ? 17'd0
                             : 17'(32'd32768 - (pm_w >> 14));
                end
                vgl_pkg::OP_NORM: begin
                    lim_reg <= 16'(({17'd0, eff_adv_reg} * {16'd0, s_reg}) >> 15);
                    // Ready one step ahead so the square root starts on it.
                    n2_reg  <= 33'({17'd0, xm_reg} * {17'd0, xm_reg})
                             + 33'({17'd0, ym_reg} * {17'd0, ym_reg});
                end
                vgl_pkg::OP_SQRT: begin
                    xo_reg <= xm_reg;
                    yo_reg <= ym_reg;
                end
                vgl_pkg::OP_DIVX: rescale_reg <= (n2_reg > lim2_w);
                vgl_pkg::OP_DIVX_END: if (rescale_reg && sq_root != 17'd0)
                    xo_reg <= div_q[15:0];
                vgl_pkg::OP_DIVY_END: if (rescale_reg && sq_root != 17'd0)
                    yo_reg <= div_q[15:0];
                default: ;
            endcase
        end
    end

    // Rotation is within +/-32767 after the clamp; magnitudes fit 16 bits,
    // except -32768 passing unchanged, which negates back to itself.
    assign rot_res = rot_reg[15:0];
    assign x_res   = xs_reg ? 16'(-xo_reg) : xo_reg;
    assign y_res   = ys_reg ? 16'(-yo_reg) : yo_reg;

    assign stat.is_command   = cmd_reg;
    assign stat.div_busy     = div_busy;
    assign stat.sqrt_busy    = sq_busy;
    assign stat.need_rescale = rescale_reg;
    assign stat.n_zero       = (sq_root == 17'd0);
endmodule

/* rtl/core/vgl_ctrl.sv */
// ----------------------------------------------------------------------------
// vgl_ctrl: sequencer of the limiter
// Steps the datapath through one beat and owns both handshakes.
// ----------------------------------------------------------------------------
module vgl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_load,
    output vgl_pkg::ctrl_t ctrl,
    input  vgl_pkg::stat_t stat
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_BRANCH, ST_GOV_WAIT, ST_EFF, ST_ROT, ST_FRAC_WAIT, ST_LIM,
        ST_NORM, ST_SQRT, ST_SQRT_WAIT, ST_DIVX_WAIT, ST_DIVY,
        ST_DIVY_WAIT, ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    // A new beat may start while the previous result waits in the output.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        ctrl.op = vgl_pkg::OP_NONE;
        m_load  = 1'b0;
        case (state_reg)
            ST_IDLE:      if (s_valid && s_ready) ctrl.op = vgl_pkg::OP_LOAD;
            ST_BRANCH:    ctrl.op = stat.is_command ? vgl_pkg::OP_EFF : vgl_pkg::OP_GOV_DIV;
            ST_GOV_WAIT:  if (!stat.div_busy) ctrl.op = vgl_pkg::OP_GOV_END;
            ST_ROT:       ctrl.op = vgl_pkg::OP_ROT;
            ST_FRAC_WAIT: if (!stat.div_busy) ctrl.op = vgl_pkg::OP_FRAC_END;
            ST_LIM:       ctrl.op = vgl_pkg::OP_LIM;
            ST_NORM:      ctrl.op = vgl_pkg::OP_NORM;
            ST_SQRT:      ctrl.op = vgl_pkg::OP_SQRT;
            ST_SQRT_WAIT: if (!stat.sqrt_busy) ctrl.op = vgl_pkg::OP_DIVX;
            ST_DIVX_WAIT: if (!stat.div_busy) ctrl.op = vgl_pkg::OP_DIVX_END;
            ST_DIVY:      ctrl.op = vgl_pkg::OP_DIVY;
            ST_DIVY_WAIT: if (!stat.div_busy) ctrl.op = vgl_pkg::OP_DIVY_END;
            // The output register takes the result once the old one is gone
            // or leaves at this edge.
            ST_OUT:       if (!m_valid_reg || m_ready) m_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_load)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:      if (s_valid && s_ready) state_reg <= ST_BRANCH;
                ST_BRANCH:    state_reg <= stat.is_command ? ST_ROT : ST_GOV_WAIT;
                ST_GOV_WAIT:  if (!stat.div_busy) state_reg <= ST_IDLE;
                ST_ROT:       state_reg <= ST_FRAC_WAIT;
                ST_FRAC_WAIT: if (!stat.div_busy) state_reg <= ST_LIM;
                ST_LIM:       state_reg <= ST_NORM;
                ST_NORM:      state_reg <= ST_SQRT;
                ST_SQRT:      state_reg <= ST_SQRT_WAIT;
                ST_SQRT_WAIT: if (!stat.sqrt_busy) state_reg <= ST_DIVX_WAIT;
                ST_DIVX_WAIT: if (!stat.div_busy) state_reg <= ST_DIVY;
                ST_DIVY:      state_reg <= ST_DIVY_WAIT;
                ST_DIVY_WAIT: if (!stat.div_busy) state_reg <= ST_OUT;
                ST_OUT:       if (m_load) state_reg <= ST_IDLE;
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/velocity_governor_limiter.sv */
// ----------------------------------------------------------------------------
// velocity_governor_limiter: speed governor and velocity command limiter
// Quality samples set a governor factor; velocity commands are clamped
// and their advance vector is rescaled to the coupled limit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  s_        in         s_valid/s_ready  command, quality_error, speeds in
//  m_        out        m_valid/m_ready  limited speeds
//  APB       in         psel/penable     six configuration registers
//
//  A quality sample runs one divide and a command three on the shared
//  one-bit-per-cycle divider (40 steps); a command also runs the 17-step
//  square root. Reset (aresetn, synchronous, low) restores the register
//  defaults and a full-speed governor. The result sits in an output
//  register; a finished command waits for the receiver to take the
//  previous result, and the input stays closed while it waits.
module velocity_governor_limiter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [23:0]        s_quality_error,
    input  logic signed [15:0] s_rotation_in,
    input  logic signed [15:0] s_advance_x_in,
    input  logic signed [15:0] s_advance_y_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_rotation_out,
    output logic signed [15:0] m_advance_x_out,
    output logic signed [15:0] m_advance_y_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [vgl_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [14:0] max_rot_reg, max_adv_reg;
    logic [15:0] gain_reg, floor_reg;
    logic [23:0] safe_reg, danger_reg;
    logic [15:0] rot_o_reg, x_o_reg, y_o_reg;
    logic signed [15:0] rot_w, x_w, y_w;
    logic        m_load;
    vgl_pkg::ctrl_t ctrl;
    vgl_pkg::stat_t stat;
    vgl_pkg::reg_index_t idx;

    assign pready = 1'b1;
    assign idx    = vgl_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rot_reg <= 15'd4096;
            max_adv_reg <= 15'd4096;
            gain_reg    <= 16'd8192;
            safe_reg    <= 24'd0;
            danger_reg  <= 24'd65536;
            floor_reg   <= 16'd6554;
        end else if (psel && penable && pwrite) begin
            case (idx)
                vgl_pkg::REG_MAX_ROT: max_rot_reg <= pwdata[14:0];
                vgl_pkg::REG_MAX_ADV: max_adv_reg <= pwdata[14:0];
                vgl_pkg::REG_GAIN:    gain_reg    <= pwdata[15:0];
                vgl_pkg::REG_SAFE:    safe_reg    <= pwdata[23:0];
                vgl_pkg::REG_DANGER:  danger_reg  <= pwdata[23:0];
                vgl_pkg::REG_FLOOR:   floor_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (idx)
            vgl_pkg::REG_MAX_ROT: prdata = {17'd0, max_rot_reg};
            vgl_pkg::REG_MAX_ADV: prdata = {17'd0, max_adv_reg};
            vgl_pkg::REG_GAIN:    prdata = {16'd0, gain_reg};
            vgl_pkg::REG_SAFE:    prdata = {8'd0, safe_reg};
            vgl_pkg::REG_DANGER:  prdata = {8'd0, danger_reg};
            vgl_pkg::REG_FLOOR:   prdata = {16'd0, floor_reg};
            default: ;
        endcase
    end

    vgl_ctrl u_ctrl (.aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
                     .m_load, .ctrl, .stat);

    vgl_datapath u_dp (
        .aclk, .aresetn, .ctrl, .stat,
        .in_command(s_command), .in_quality(s_quality_error),
        .in_rot(s_rotation_in), .in_x(s_advance_x_in), .in_y(s_advance_y_in),
        .max_rot(max_rot_reg), .max_adv(max_adv_reg), .gain(gain_reg),
        .safe(safe_reg), .danger(danger_reg), .floor_q(floor_reg),
        .rot_res(rot_w), .x_res(x_w), .y_res(y_w));

    // All three components are final once the controller reaches its output state and issues the load.
    always_ff @(posedge aclk) begin
        if (m_load) begin
            rot_o_reg <= rot_w;
            x_o_reg   <= x_w;
            y_o_reg   <= y_w;
        end
    end

    assign m_rotation_out  = rot_o_reg;
    assign m_advance_x_out = x_o_reg;
    assign m_advance_y_out = y_o_reg;
endmodule
